@@ design/slmfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmfe_pkg: shared types and constants of the scrolling LED matrix engine
// Item types, command codes, register addresses and store geometry.
// ----------------------------------------------------------------------------
package slmfe_pkg;

	localparam int MODULES     = 4;
	localparam int MAX_COLUMNS = 64;
	localparam int MAX_RESULTS = 32;
	localparam int ROWS        = 8;

	localparam int MODS   = (MODULES < MAX_RESULTS / 8) ? MODULES : MAX_RESULTS / 8;
	localparam int MOD_W  = (MODS > 1) ? $clog2(MODS) : 1;
	localparam int DEPTH  = ROWS * MAX_COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ($clog2(MAX_COLUMNS + 2) > 7) ? $clog2(MAX_COLUMNS + 2) : 7;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SHIFT = 2'd1;
	localparam logic [1:0] CMD_SHOW  = 2'd2;
	localparam logic [1:0] CMD_INIT  = 2'd3;

	localparam logic [3:0] REG_DECODE    = 4'h9;
	localparam logic [3:0] REG_INTENSITY = 4'hA;
	localparam logic [3:0] REG_SCAN      = 4'hB;
	localparam logic [3:0] REG_TEST      = 4'hF;
	localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
	localparam logic [7:0] SHUTDOWN_RUN  = 8'h01;

	localparam logic [2:0] CFG_LENGTH     = 3'd0;
	localparam logic [2:0] CFG_DECODE     = 3'd1;
	localparam logic [2:0] CFG_BRIGHTNESS = 3'd2;
	localparam logic [2:0] CFG_SCAN       = 3'd3;
	localparam logic [2:0] CFG_TEST       = 3'd4;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] row;
		logic [5:0] column;
		logic [7:0] glyph_byte;
		logic [3:0] shift_amount;
	} cmd_t;

	typedef struct packed {
		logic [3:0] reg_address;
		logic [7:0] reg_data;
		logic       latch_after;
		logic       last_of_run;
	} word_t;

	function automatic logic [ADDR_W-1:0] store_addr(input logic [2:0] row,
			input logic [CNT_W-1:0] col);
		logic [ADDR_W+CNT_W-1:0] full;
		full = (ADDR_W+CNT_W)'(row) * (ADDR_W+CNT_W)'(MAX_COLUMNS) + (ADDR_W+CNT_W)'(col);
		return full[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ design/scrolling_led_matrix_frame_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scrolling_led_matrix_frame_engine: frame store and word sequencer
// Holds eight rows of glyph bytes and emits driver register words.
// ----------------------------------------------------------------------------
// A load writes one byte into the frame store. A shift rewrites the L message columns of
// each row through the single read port of the frame store and the one shared byte shifter.
// A show emits 8*MODS words, one per read of the frame store; an init emits five words.
// Only one item is in work at a time; a finished word waits in an output register.
// Reset clears control state and loads the register reset values; the frame
// store is not cleared and is undefined until written.
module scrolling_led_matrix_frame_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire slmfe_pkg::cmd_t   cmd,
	output logic                   word_valid,
	input  wire logic              word_ready,
	output slmfe_pkg::word_t       word,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import slmfe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SHOW_RD,
		ST_SHOW_OUT,
		ST_INIT
	} state_t;

	state_t            state_q;
	logic [6:0]        length_q;
	logic [7:0]        decode_q;
	logic [3:0]        bright_q;
	logic [2:0]        scan_q;
	logic              test_q;
	logic [CNT_W-1:0]  len_eff;

	logic [2:0]        row_q;
	logic [CNT_W-1:0]  col_q;
	logic [MOD_W-1:0]  mod_q;
	logic [2:0]        init_q;
	logic [3:0]        amt_q;
	logic [7:0]        first_q;
	logic [7:0]        prev_q;
	logic              valid_s1;
	logic [CNT_W-1:0]  col_s1;
	logic              word_valid_q;
	word_t             word_q;

	logic [7:0]        mem [0:DEPTH-1];
	logic [7:0]        mem_rdata_q;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;

	logic              cmd_fire;
	logic              cfg_write;
	logic              out_free;
	logic              word_load;
	logic              issue;
	logic [7:0]        cur_byte;
	logic [15:0]       shift_pair;
	logic [7:0]        shifted;
	logic              mod_last;
	logic [7:0]        show_data;
	word_t             show_word;
	word_t             init_word;

	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite && pready;
	assign cmd_ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd_valid && cmd_ready;
	assign word_valid = word_valid_q;
	assign word       = word_q;
	assign out_free   = !word_valid_q || word_ready;
	assign word_load  = out_free && (state_q == ST_SHOW_OUT || state_q == ST_INIT);

	always_comb begin
		if (length_q == 7'd0) begin
			len_eff = CNT_W'(1);
		end else if (CNT_W'(length_q) > CNT_W'(MAX_COLUMNS)) begin
			len_eff = CNT_W'(MAX_COLUMNS);
		end else begin
			len_eff = CNT_W'(length_q);
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			CFG_LENGTH:     prdata = {25'd0, length_q};
			CFG_DECODE:     prdata = {24'd0, decode_q};
			CFG_BRIGHTNESS: prdata = {28'd0, bright_q};
			CFG_SCAN:       prdata = {29'd0, scan_q};
			CFG_TEST:       prdata = {31'd0, test_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign issue      = (state_q == ST_SHIFT) && (col_q <= len_eff);
	assign cur_byte   = (col_s1 == len_eff) ? first_q : mem_rdata_q;
	assign shift_pair = {prev_q, cur_byte} << amt_q;
	assign shifted    = shift_pair[15:8];

	assign mod_last  = (mod_q == MOD_W'(MODS - 1));
	assign show_data = (CNT_W'(mod_q) < len_eff) ? mem_rdata_q : 8'd0;
	always_comb begin
		show_word.reg_address = 4'(row_q) + 4'd1;
		show_word.reg_data    = show_data;
		show_word.latch_after = mod_last;
		show_word.last_of_run = mod_last && (row_q == 3'd7);
	end

	always_comb begin
		init_word.latch_after = 1'b1;
		init_word.last_of_run = 1'b0;
		unique case (init_q)
			3'd0: begin
				init_word.reg_address = REG_DECODE;
				init_word.reg_data    = decode_q;
			end
			3'd1: begin
				init_word.reg_address = REG_INTENSITY;
				init_word.reg_data    = {4'd0, bright_q};
			end
			3'd2: begin
				init_word.reg_address = REG_SCAN;
				init_word.reg_data    = {5'd0, scan_q};
			end
			3'd3: begin
				init_word.reg_address = REG_TEST;
				init_word.reg_data    = {7'd0, test_q};
			end
			default: begin
				init_word.reg_address = REG_SHUTDOWN;
				init_word.reg_data    = SHUTDOWN_RUN;
				init_word.last_of_run = 1'b1;
			end
		endcase
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = store_addr(row_q, col_q);
		mem_we    = 1'b0;
		mem_waddr = store_addr(cmd.row, CNT_W'(cmd.column));
		mem_wdata = cmd.glyph_byte;
		if (state_q == ST_SHIFT) begin
			mem_re    = issue && (col_q < len_eff);
			mem_we    = valid_s1 && (col_s1 != '0);
			mem_waddr = store_addr(row_q, col_s1 - CNT_W'(1));
			mem_wdata = shifted;
		end else if (state_q == ST_SHOW_RD) begin
			mem_re    = 1'b1;
			mem_raddr = store_addr(row_q, CNT_W'(mod_q));
		end else if (cmd_fire && cmd.command == CMD_LOAD) begin
			mem_we = CNT_W'(cmd.column) < CNT_W'(MAX_COLUMNS);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= 7'd1;
			decode_q <= 8'd0;
			bright_q <= 4'd0;
			scan_q   <= 3'd7;
			test_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				CFG_LENGTH:     length_q <= pwdata[6:0];
				CFG_DECODE:     decode_q <= pwdata[7:0];
				CFG_BRIGHTNESS: bright_q <= pwdata[3:0];
				CFG_SCAN:       scan_q   <= pwdata[2:0];
				CFG_TEST:       test_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_q        <= 3'd0;
			col_q        <= '0;
			mod_q        <= '0;
			init_q       <= 3'd0;
			amt_q        <= 4'd0;
			first_q      <= 8'd0;
			prev_q       <= 8'd0;
			valid_s1     <= 1'b0;
			col_s1       <= '0;
			word_valid_q <= 1'b0;
			word_q       <= '0;
		end else begin
			if (word_ready && !word_load) begin
				word_valid_q <= 1'b0;
			end
			valid_s1 <= issue;
			if (issue) begin
				col_s1 <= col_q;
				col_q  <= col_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					row_q  <= 3'd0;
					col_q  <= '0;
					mod_q  <= '0;
					init_q <= 3'd0;
					if (cmd_fire) begin
						unique case (cmd.command)
							CMD_SHIFT: begin
								state_q <= ST_SHIFT;
								amt_q   <= (cmd.shift_amount > 4'd8) ? 4'd8 : cmd.shift_amount;
							end
							CMD_SHOW: state_q <= ST_SHOW_RD;
							CMD_INIT: state_q <= ST_INIT;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SHIFT: begin
					if (valid_s1) begin
						prev_q <= cur_byte;
						if (col_s1 == '0) begin
							first_q <= cur_byte;
						end
						if (col_s1 == len_eff) begin
							col_q <= '0;
							row_q <= row_q + 3'd1;
							if (row_q == 3'd7) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_SHOW_RD: begin
					state_q <= ST_SHOW_OUT;
				end
				ST_SHOW_OUT: begin
					if (out_free) begin
						word_valid_q <= 1'b1;
						word_q       <= show_word;
						if (mod_last) begin
							mod_q <= '0;
							row_q <= row_q + 3'd1;
						end else begin
							mod_q <= mod_q + MOD_W'(1);
						end
						state_q <= show_word.last_of_run ? ST_IDLE : ST_SHOW_RD;
					end
				end
				ST_INIT: begin
					if (out_free) begin
						word_valid_q <= 1'b1;
						word_q       <= init_word;
						init_q       <= init_q + 3'd1;
						if (init_word.last_of_run) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/slmfe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmfe_checker: port-level checks for the frame engine
// Watches the command, word and register ports over time.
// ----------------------------------------------------------------------------
module slmfe_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire slmfe_pkg::cmd_t   cmd,
	input wire logic              word_valid,
	input wire logic              word_ready,
	input wire slmfe_pkg::word_t  word,
	input wire logic              pready
);
	import slmfe_pkg::*;

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(word))
		else $error("A stalled word changed or was dropped.");

	a_busy_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.command != CMD_LOAD |=> !cmd_ready)
		else $error("Engine took a new item while a shift, show or init was in work.");

	a_last_latches: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word.last_of_run |-> word.latch_after)
		else $error("The final word of a run does not latch.");

	a_setup_latches: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && (word.reg_address == REG_DECODE || word.reg_address == REG_INTENSITY ||
		word.reg_address == REG_SCAN || word.reg_address == REG_TEST ||
		word.reg_address == REG_SHUTDOWN) |-> word.latch_after)
		else $error("A set-up word does not latch.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("The register port stalled.");

endmodule

bind scrolling_led_matrix_frame_engine slmfe_checker u_slmfe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd_valid),
	.cmd_ready  (cmd_ready),
	.cmd        (cmd),
	.word_valid (word_valid),
	.word_ready (word_ready),
	.word       (word),
	.pready     (pready)
);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for scrolling_led_matrix_frame_engine
// Drives load, shift, show and init items through the command channel and
// checks every emitted register word against a cycle-free model of the frame
// store and the set-up registers. The run steps through several register
// settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import slmfe_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_t        cmd = '0;
	logic        word_valid;
	logic        word_ready = 1'b0;
	word_t       word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	scrolling_led_matrix_frame_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	// Model of the frame store and the set-up registers.
	logic [7:0] frame_bytes [ROWS][MAX_COLUMNS];
	logic [6:0] cfg_length = 7'd1;
	logic [7:0] cfg_decode = 8'd0;
	logic [3:0] cfg_brightness = 4'd0;
	logic [2:0] cfg_scan = 3'd7;
	logic       cfg_test = 1'b0;

	word_t expected_words [$];
	cmd_t  pending_cmds [$];
	bit    written_map [ROWS][MAX_COLUMNS];
	int    sent_count = 0;
	int    taken_count = 0;
	int    fail_count = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    plan_len = 1;
	logic  cmd_taken = 1'b0;

	function automatic int clamp_length(input int len);
		return (len < 1) ? 1 : (len > MAX_COLUMNS) ? MAX_COLUMNS : len;
	endfunction

	task automatic predict_words(input cmd_t c);
		int len;
		int amt;
		logic [7:0] first_byte;
		logic [7:0] next_byte;
		logic [15:0] pair;
		word_t w;
		len = clamp_length(cfg_length);
		case (c.command)
			CMD_LOAD: begin
				frame_bytes[c.row][c.column] = c.glyph_byte;
			end
			CMD_SHIFT: begin
				amt = (c.shift_amount > 4'd8) ? 8 : c.shift_amount;
				for (int r = 0; r < ROWS; r++) begin
					first_byte = frame_bytes[r][0];
					for (int x = 0; x < len; x++) begin
						next_byte = (x + 1 < len) ? frame_bytes[r][x + 1] : first_byte;
						pair = {frame_bytes[r][x], next_byte} << amt;
						frame_bytes[r][x] = pair[15:8];
					end
				end
			end
			CMD_SHOW: begin
				for (int r = 0; r < ROWS; r++) begin
					for (int x = 0; x < MODS; x++) begin
						w.reg_address = 4'(r + 1);
						w.reg_data = (x < len) ? frame_bytes[r][x] : 8'd0;
						w.latch_after = (x == MODS - 1);
						w.last_of_run = (x == MODS - 1) && (r == ROWS - 1);
						expected_words.push_back(w);
					end
				end
			end
			default: begin
				expected_words.push_back('{REG_DECODE, cfg_decode, 1'b1, 1'b0});
				expected_words.push_back('{REG_INTENSITY, 8'(cfg_brightness), 1'b1, 1'b0});
				expected_words.push_back('{REG_SCAN, 8'(cfg_scan), 1'b1, 1'b0});
				expected_words.push_back('{REG_TEST, 8'(cfg_test), 1'b1, 1'b0});
				expected_words.push_back('{REG_SHUTDOWN, SHUTDOWN_RUN, 1'b1, 1'b1});
			end
		endcase
	endtask

	// Command driver.
	always @(negedge clk) begin
		if (!cmd_valid || cmd_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
				sent_count++;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		word_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: checks emitted words, then predicts from accepted items.
	always @(posedge clk) begin : monitor
		word_t want;
		if (arst_n) begin
			cmd_taken <= cmd_valid && cmd_ready;
			if (word_valid && word_ready) begin
				if (expected_words.size() == 0) begin
					$error("word %0h/%0h/%0b/%0b arrived with nothing expected",
						word.reg_address, word.reg_data, word.latch_after, word.last_of_run);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (word.reg_address !== want.reg_address) begin
						$error("reg_address: expected %0h, got %0h",
							want.reg_address, word.reg_address);
						fail_count++;
					end
					if (word.reg_data !== want.reg_data) begin
						$error("reg_data: expected %0h, got %0h", want.reg_data, word.reg_data);
						fail_count++;
					end
					if (word.latch_after !== want.latch_after) begin
						$error("latch_after: expected %0b, got %0b",
							want.latch_after, word.latch_after);
						fail_count++;
					end
					if (word.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							want.last_of_run, word.last_of_run);
						fail_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				predict_words(cmd);
				taken_count++;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					CFG_LENGTH:     cfg_length = pwdata[6:0];
					CFG_DECODE:     cfg_decode = pwdata[7:0];
					CFG_BRIGHTNESS: cfg_brightness = pwdata[3:0];
					CFG_SCAN:       cfg_scan = pwdata[2:0];
					CFG_TEST:       cfg_test = pwdata[0];
					default: ;
				endcase
			end
		end
	end

	task automatic queue_command(input logic [1:0] command, input int row, input int column,
			input int glyph, input int amt);
		cmd_t c;
		c.command = command;
		c.row = 3'(row);
		c.column = 6'(column);
		c.glyph_byte = 8'(glyph);
		c.shift_amount = 4'(amt);
		if (command == CMD_LOAD)
			written_map[c.row][c.column] = 1'b1;
		pending_cmds.push_back(c);
	endtask

	task automatic write_register(input logic [2:0] index, input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() != 0 || sent_count != taken_count
				|| expected_words.size() != 0)
			@(negedge clk);
	endtask

	// Waits for the queues to drain, then long enough for a shift over the full store to finish.
	task automatic settle();
		wait_drained();
		repeat (600) @(negedge clk);
	endtask

	task automatic run_phase(input int len, input int decode, input int bright, input int scan,
			input int test, input int send_idle, input int recv_stall, input int count,
			input bit pause_mid, input bit with_shift);
		int pick;
		int col;
		int amt;
		int fill_len;
		logic [1:0] kind;
		settle();
		write_register(CFG_LENGTH, len);
		write_register(CFG_DECODE, decode);
		write_register(CFG_BRIGHTNESS, bright);
		write_register(CFG_SCAN, scan);
		write_register(CFG_TEST, test);
		plan_len = clamp_length(len & 'h7f);
		fill_len = (with_shift || plan_len < MODS) ? plan_len : MODS;
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		// Every column whose byte a shift or show will use must hold a written byte.
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < fill_len; c++)
				if (!written_map[r][c])
					queue_command(CMD_LOAD, r, c, $urandom_range(255), $urandom_range(15));
		for (int n = 0; n < count; n++) begin
			if (pause_mid && n == count / 2)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 45)
				kind = CMD_LOAD;
			else if (pick < 65)
				kind = with_shift ? CMD_SHIFT : CMD_SHOW;
			else if (pick < 90)
				kind = CMD_SHOW;
			else
				kind = CMD_INIT;
			col = ($urandom_range(3) != 0) ? $urandom_range(plan_len - 1) : $urandom_range(63);
			amt = ($urandom_range(3) != 0) ? $urandom_range(8) : $urandom_range(15);
			queue_command(kind, $urandom_range(7), col, $urandom_range(255), amt);
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed items with the reset settings, so only column zero is in the message.
		queue_command(CMD_LOAD, 0, 0, 8'h00, 0);
		queue_command(CMD_LOAD, 1, 0, 8'hFF, 15);
		queue_command(CMD_LOAD, 2, 0, 8'h80, 0);
		queue_command(CMD_LOAD, 3, 0, 8'h01, 0);
		queue_command(CMD_LOAD, 4, 0, 8'hA5, 0);
		queue_command(CMD_LOAD, 5, 0, 8'h5A, 0);
		queue_command(CMD_LOAD, 6, 0, 8'h7F, 0);
		queue_command(CMD_LOAD, 7, 0, 8'hFE, 0);
		queue_command(CMD_SHOW, 0, 0, 0, 0);
		queue_command(CMD_INIT, 7, 63, 8'hFF, 15);
		queue_command(CMD_SHIFT, 7, 63, 8'hFF, 0);
		queue_command(CMD_SHOW, 7, 63, 8'hFF, 15);
		queue_command(CMD_SHIFT, 0, 0, 0, 8);
		queue_command(CMD_SHIFT, 0, 0, 0, 3);
		queue_command(CMD_SHOW, 0, 0, 0, 0);
		queue_command(CMD_SHIFT, 0, 0, 0, 15);
		queue_command(CMD_SHOW, 0, 0, 0, 0);
		queue_command(CMD_LOAD, 7, 63, 8'hFF, 0);
		queue_command(CMD_LOAD, 5, 42, 8'h3C, 0);
		queue_command(CMD_SHOW, 0, 0, 0, 0);

		run_phase(8, $urandom_range(255), $urandom_range(15), $urandom_range(7),
			$urandom_range(1), 0, 0, 25, 1'b0, 1'b1);
		run_phase(0, 255, 15, 7, 1, 83, 0, 25, 1'b0, 1'b1);
		run_phase(3, 0, 0, 0, 0, 0, 83, 25, 1'b0, 1'b1);
		run_phase($urandom_range(5, 12), $urandom_range(255), $urandom_range(15),
			$urandom_range(7), $urandom_range(1), 6, 6, 25, 1'b0, 1'b1);
		run_phase(127, $urandom_range(255), $urandom_range(15), $urandom_range(7),
			$urandom_range(1), 0, 0, 25, 1'b1, 1'b0);

		settle();
		if (fail_count == 0)
			$display("scrolling_led_matrix_frame_engine verification clean");
		else
			$display("scrolling_led_matrix_frame_engine verification failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("scrolling_led_matrix_frame_engine verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/slmfe_pkg.sv
design/scrolling_led_matrix_frame_engine.sv
design/slmfe_checker.sv
verif/tb.sv
